FILE: hdl/dca_pkg.sv
package dca_pkg;

  // Default largest packet the block tracks, in bytes.
  localparam int MAX_PACKET_DEF = 512;

  // Fixed sizes of the DNS header and of the appended answer record.
  localparam int HEADER_BYTES = 12;
  localparam int ANSWER_BYTES = 16;
  localparam int ANS_IDX_W = $clog2(ANSWER_BYTES);

  // Label offsets are tracked in ten bits and saturate at the top value.
  localparam int LABEL_W = 10;
  localparam int LABEL_POS_MAX = (1 << LABEL_W) - 1;

  // Common width for offset arithmetic, wide enough for any sum that occurs.
  localparam int CMP_W = 12;

  // The zero byte plus QTYPE and QCLASS must fit inside the packet.
  localparam int QUESTION_TAIL = 5;

  // Header offsets that are rewritten.
  localparam logic [3:0] OFS_FLAGS_HI   = 4'd2;
  localparam logic [3:0] OFS_FLAGS_LO   = 4'd3;
  localparam logic [3:0] OFS_ANCOUNT_HI = 4'd6;
  localparam logic [3:0] OFS_ANCOUNT_LO = 4'd7;
  localparam logic [3:0] OFS_NSCOUNT_HI = 4'd8;
  localparam logic [3:0] OFS_ARCOUNT_LO = 4'd11;

  // Response header values.
  localparam logic [7:0] FLAGS_HI_VAL = 8'h81;
  localparam logic [7:0] FLAGS_LO_VAL = 8'h80;
  localparam logic [15:0] ANCOUNT_VAL = 16'h0001;

  // Answer record fields.
  localparam logic [15:0] NAME_PTR   = 16'hC00C;
  localparam logic [15:0] TYPE_A     = 16'h0001;
  localparam logic [15:0] CLASS_IN   = 16'h0001;
  localparam logic [31:0] ANSWER_TTL = 32'd30;
  localparam logic [15:0] RDLENGTH   = 16'd4;

  // One response word as it leaves the parser.
  typedef struct packed {
    logic [7:0] data;
    logic       eop;
    logic       drop;
    logic       start_answer;
  } echo_t;

  // Rewrites one header byte at the given offset.
  function automatic logic [7:0] header_byte(input logic [3:0] ofs, input logic [7:0] d);
    logic [7:0] res;
    res = d;
    case (ofs)
      OFS_FLAGS_HI:   res = FLAGS_HI_VAL;
      OFS_FLAGS_LO:   res = FLAGS_LO_VAL;
      OFS_ANCOUNT_HI: res = ANCOUNT_VAL[15:8];
      OFS_ANCOUNT_LO: res = ANCOUNT_VAL[7:0];
      default: begin
        if (ofs inside {[OFS_NSCOUNT_HI:OFS_ARCOUNT_LO]}) begin
          res = 8'h00;
        end
      end
    endcase
    return res;
  endfunction

  // Picks one byte of the answer record, first byte at index zero.
  function automatic logic [7:0] answer_byte(input logic [ANS_IDX_W-1:0] idx,
                                             input logic [31:0] ip);
    logic [ANSWER_BYTES*8-1:0] rec;
    rec = {NAME_PTR, TYPE_A, CLASS_IN, ANSWER_TTL, RDLENGTH, ip};
    return rec[ANSWER_BYTES*8-1 - 8*idx -: 8];
  endfunction

endpackage

FILE: hdl/dns_captive_a_responder.sv
// DNS responder for a captive portal. Query bytes stream in one word per
// cycle while the output is not stalled and no answer is being sent; the
// response streams out cut-through, registered once in the output register,
// with the header flags set to 81 80, ANCOUNT to 1 and NSCOUNT and ARCOUNT
// to 0. At the end of a well formed query a 16-byte A record follows,
// pointing back at the question name, TTL 30, carrying answer_ip in network
// byte order; query_ready stays low while the answer counter walks it. A
// query shorter than 12 bytes, longer than MAX_PACKET - 16 bytes, or with a
// broken name or a missing QTYPE/QCLASS gets no answer, and its last word
// carries both end_of_packet and drop_packet. Write answer_ip only while no
// query is in flight.
module dns_captive_a_responder #(
  parameter int MAX_PACKET = dca_pkg::MAX_PACKET_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        answer_ip_we,
  input  logic [31:0] answer_ip_wdata,
  input  logic        query_valid,
  output logic        query_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        reply_valid,
  input  logic        reply_ready,
  output logic [7:0]  out_byte,
  output logic        end_of_packet,
  output logic        drop_packet
);

  logic [31:0]    answer_ip;
  dca_pkg::echo_t echo;
  logic           load;
  logic           accept;
  logic           ans_busy;
  logic [7:0]     ans_data;
  logic           ans_eop;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      answer_ip <= '0;
    end else if (answer_ip_we) begin
      answer_ip <= answer_ip_wdata;
    end
  end

  // The output register loads whenever it is empty or being drained.
  assign load        = !reply_valid || reply_ready;
  assign query_ready = load && !ans_busy;
  assign accept      = query_valid && query_ready;

  dca_parse #(
    .MAX_PACKET(MAX_PACKET)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .echo     (echo)
  );

  dca_answer u_answer (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && echo.start_answer),
    .advance  (load),
    .answer_ip(answer_ip),
    .busy     (ans_busy),
    .data     (ans_data),
    .eop      (ans_eop)
  );

  // Output register: echoed query words, then answer words.
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_valid <= 1'b0;
    end else if (load) begin
      reply_valid <= accept || ans_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (accept) begin
        out_byte      <= echo.data;
        end_of_packet <= echo.eop;
        drop_packet   <= echo.drop;
      end else begin
        out_byte      <= ans_data;
        end_of_packet <= ans_eop;
        drop_packet   <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/dca_parse.sv
module dca_parse #(
  parameter int MAX_PACKET = dca_pkg::MAX_PACKET_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  output dca_pkg::echo_t  echo
);

  localparam int POS_W = $clog2(MAX_PACKET + 1);
  localparam int CMP_W = dca_pkg::CMP_W;
  localparam int LABEL_W = dca_pkg::LABEL_W;

  logic [POS_W-1:0]   byte_position;
  logic [LABEL_W-1:0] next_label_position;
  logic               name_complete;
  logic [LABEL_W-1:0] name_end_position;

  logic [POS_W-1:0]   byte_position_next;
  logic [LABEL_W-1:0] next_label_position_next;
  logic               name_complete_next;
  logic [LABEL_W-1:0] name_end_position_next;

  logic               in_range;
  logic               label_hit;
  logic [CMP_W-1:0]   pos_x;
  logic [CMP_W-1:0]   jump;
  logic [CMP_W-1:0]   len_x;
  logic               ok;

  // Header rewrite and QNAME label walk for the word at the input.
  always_comb begin
    in_range  = byte_position < POS_W'(MAX_PACKET);
    pos_x     = CMP_W'(byte_position);
    jump      = pos_x + CMP_W'(1) + CMP_W'(data_byte);
    label_hit = in_range && !name_complete && (pos_x == CMP_W'(next_label_position));

    byte_position_next       = byte_position;
    next_label_position_next = next_label_position;
    name_complete_next       = name_complete;
    name_end_position_next   = name_end_position;

    if (in_range) begin
      byte_position_next = byte_position + POS_W'(1);
    end
    if (label_hit) begin
      if (data_byte == 8'h00) begin
        name_complete_next     = 1'b1;
        name_end_position_next = pos_x[LABEL_W-1:0];
      end else if (jump > CMP_W'(dca_pkg::LABEL_POS_MAX)) begin
        next_label_position_next = LABEL_W'(dca_pkg::LABEL_POS_MAX);
      end else begin
        next_label_position_next = jump[LABEL_W-1:0];
      end
    end

    // Well formed check on the length as it stands after this word.
    len_x = CMP_W'(byte_position_next);
    ok = (len_x >= CMP_W'(dca_pkg::HEADER_BYTES))
      && (len_x <= CMP_W'(MAX_PACKET - dca_pkg::ANSWER_BYTES))
      && name_complete_next
      && (CMP_W'(name_end_position_next) + CMP_W'(dca_pkg::QUESTION_TAIL) <= len_x);

    echo.data = data_byte;
    if (in_range && (pos_x < CMP_W'(dca_pkg::HEADER_BYTES))) begin
      echo.data = dca_pkg::header_byte(pos_x[3:0], data_byte);
    end
    echo.eop          = last_byte && !ok;
    echo.drop         = last_byte && !ok;
    echo.start_answer = last_byte && ok;
  end

  // Packet state; it returns to its idle values after every last word.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      next_label_position <= LABEL_W'(dca_pkg::HEADER_BYTES);
      name_complete       <= 1'b0;
      name_end_position   <= '0;
    end else if (accept) begin
      if (last_byte) begin
        byte_position       <= '0;
        next_label_position <= LABEL_W'(dca_pkg::HEADER_BYTES);
        name_complete       <= 1'b0;
        name_end_position   <= '0;
      end else begin
        byte_position       <= byte_position_next;
        next_label_position <= next_label_position_next;
        name_complete       <= name_complete_next;
        name_end_position   <= name_end_position_next;
      end
    end
  end

endmodule

FILE: hdl/dca_answer.sv
module dca_answer (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        advance,
  input  logic [31:0] answer_ip,
  output logic        busy,
  output logic [7:0]  data,
  output logic        eop
);

  localparam int IDX_W = dca_pkg::ANS_IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(dca_pkg::ANSWER_BYTES - 1);

  logic [IDX_W-1:0] idx;

  // Walks through the answer record one word per advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (advance && busy) begin
      if (idx == LAST_IDX) begin
        busy <= 1'b0;
      end
      idx <= idx + IDX_W'(1);
    end
  end

  // Current answer word.
  assign data = dca_pkg::answer_byte(idx, answer_ip);
  assign eop  = (idx == LAST_IDX);

endmodule

FILE: hdl/dca_check.sv
module dca_check (
  input logic       clk,
  input logic       rst,
  input logic       query_ready,
  input logic       reply_valid,
  input logic       reply_ready,
  input logic [7:0] out_byte,
  input logic       end_of_packet,
  input logic       drop_packet
);

  // A stalled reply word stays valid and unchanged.
  a_reply_hold: assert property (@(posedge clk) disable iff (rst)
    reply_valid && !reply_ready |=> reply_valid && $stable(out_byte)
      && $stable(end_of_packet) && $stable(drop_packet))
    else $error("reply word changed while stalled");

  // A drop mark only ever sits on the last word of a response.
  a_drop_eop: assert property (@(posedge clk) disable iff (rst)
    reply_valid && drop_packet |-> end_of_packet)
    else $error("drop mark without end of packet");

  // No new query word is taken while the output is blocked.
  a_no_take_stalled: assert property (@(posedge clk) disable iff (rst)
    reply_valid && !reply_ready |-> !query_ready)
    else $error("query taken while reply stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !reply_valid)
    else $error("reply valid right after reset");

endmodule

bind dns_captive_a_responder dca_check u_check (.*);
